// ===== rtl/core/bwr_pkg.sv =====
package bwr_pkg;

    localparam int POS_W   = 7;
    localparam int CNT_W   = 14;
    localparam int PCT_W   = 7;
    localparam int LVL_W   = 4;
    localparam int LUMA_W  = 8;
    localparam int AREA_W  = 14;
    localparam int NUM_W   = 21;
    localparam int STEP_W  = 5;
    localparam int PIX_W   = 16;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0] TALLY_MAX = '1;
    localparam logic [PCT_W-1:0] PCT_MAX   = '1;
    localparam logic [6:0]       PCT_SCALE = 7'd100;
    localparam logic [7:0]       CHAR_E    = 8'd69;
    localparam logic [7:0]       CHAR_S    = 8'd83;

    localparam logic [POS_W-1:0]  RST_ROW_START = 7'd72;
    localparam logic [POS_W-1:0]  RST_ROW_END   = 7'd96;
    localparam logic [POS_W-1:0]  RST_COL_START = 7'd24;
    localparam logic [POS_W-1:0]  RST_COL_END   = 7'd72;
    localparam logic [PCT_W-1:0]  RST_PCT_LIMIT = 7'd15;
    localparam logic [LVL_W-1:0]  RST_DEB_FRAMES = 4'd3;
    localparam logic [LUMA_W-1:0] RST_LUMA_LIMIT = 8'd180;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_START  = 3'd0,
        CFG_ROW_END    = 3'd1,
        CFG_COL_START  = 3'd2,
        CFG_COL_END    = 3'd3,
        CFG_PCT_LIMIT  = 3'd4,
        CFG_DEB_FRAMES = 3'd5,
        CFG_LUMA_LIMIT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0]  row_start;
        logic [POS_W-1:0]  row_end;
        logic [POS_W-1:0]  col_start;
        logic [POS_W-1:0]  col_end;
        logic [PCT_W-1:0]  pct_limit;
        logic [LVL_W-1:0]  deb_frames;
        logic [LUMA_W-1:0] luma_limit;
    } t_bwr_cfg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FIN
    } t_bk_state;

    function automatic logic [POS_W-1:0] bwr_clip(
        input logic [POS_W-1:0] v,
        input logic [POS_W-1:0] lim
    );
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== rtl/core/bwr_queue.sv =====
module bwr_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [bwr_pkg::CNT_W-1:0] i_push_data,
    output logic                      o_full,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [bwr_pkg::CNT_W-1:0] o_head
);
    import bwr_pkg::*;

    logic [CNT_W-1:0] r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_fill, n_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_fill   = r_fill + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/core/bwr_front.sv =====
module bwr_front #(
    parameter int FRAME_WIDTH  = 96,
    parameter int FRAME_HEIGHT = 96
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bwr_pkg::t_bwr_cfg         i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [bwr_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_last,
    input  logic                      i_q_full,
    output logic                      o_push,
    output logic [bwr_pkg::CNT_W-1:0] o_push_data
);
    import bwr_pkg::*;

    localparam logic [POS_W-1:0] FW = POS_W'(FRAME_WIDTH);
    localparam logic [POS_W-1:0] FH = POS_W'(FRAME_HEIGHT);

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_tally, n_tally;
    logic             r_s1_vld, n_s1_vld;
    logic             r_s1_last, r_s1_inband;
    logic [7:0]       r_r8, r_g8, r_b8;

    logic [POS_W-1:0] rs, re, cs, ce;
    logic             accept, consume, inband, white;
    logic [7:0]       y_r, z_g, x_b, r8, g8, b8;
    logic [15:0]      p_r, p_b, luma_sum;
    logic [17:0]      p_g;
    logic [CNT_W-1:0] tally_inc;

    always_comb begin
        rs = bwr_clip(i_cfg.row_start, FH);
        re = bwr_clip(i_cfg.row_end, FH);
        cs = bwr_clip(i_cfg.col_start, FW);
        ce = bwr_clip(i_cfg.col_end, FW);
        inband = (r_row < FH) && (r_row >= rs) && (r_row < re)
                 && (r_col >= cs) && (r_col < ce);
    end

    // rounded / floored 5-6-5 to 8 bit expansion by reciprocal multiply
    always_comb begin
        y_r = 8'(i_pixel[15:11]) * 8'd7 + 8'd15;
        z_g = 8'(i_pixel[10:5]) * 8'd3 + 8'd31;
        x_b = 8'(i_pixel[4:0]) * 8'd7;
        p_r = 16'(y_r) * 16'd265;
        p_g = 18'(z_g) * 18'd1041;
        p_b = 16'(x_b) * 16'd265;
        r8  = {i_pixel[15:11], 3'b000} + 8'(p_r[15:13]);
        g8  = {i_pixel[10:5], 2'b00} + 8'(p_g[17:16]);
        b8  = {i_pixel[4:0], 3'b000} + 8'(p_b[15:13]);
    end

    assign o_ready = !r_s1_vld || !r_s1_last || !i_q_full;
    assign accept  = i_valid && o_ready;
    assign consume = r_s1_vld && o_ready;

    always_comb begin
        luma_sum  = 16'(r_r8) * 16'd77 + 16'(r_g8) * 16'd150 + 16'(r_b8) * 16'd29;
        white     = r_s1_inband && (luma_sum[15:8] > i_cfg.luma_limit);
        tally_inc = (white && (r_tally != TALLY_MAX)) ? r_tally + 1'b1 : r_tally;
    end

    assign o_push      = consume && r_s1_last;
    assign o_push_data = tally_inc;

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_tally  = r_tally;
        n_s1_vld = r_s1_vld;
        if (consume) begin
            n_s1_vld = 1'b0;
            n_tally  = r_s1_last ? '0 : tally_inc;
        end
        if (accept) begin
            n_s1_vld = 1'b1;
            if (i_last) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col + 1'b1 >= FW) begin
                n_col = '0;
                n_row = (r_row < FH) ? r_row + 1'b1 : r_row;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_tally  <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_tally  <= n_tally;
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last   <= i_last;
            r_s1_inband <= inband;
            r_r8        <= r8;
            r_g8        <= g8;
            r_b8        <= b8;
        end
    end

endmodule

// ===== rtl/core/bwr_back.sv =====
module bwr_back #(
    parameter int FRAME_WIDTH  = 96,
    parameter int FRAME_HEIGHT = 96
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bwr_pkg::t_bwr_cfg         i_cfg,
    input  logic                      i_q_empty,
    input  logic [bwr_pkg::CNT_W-1:0] i_q_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [bwr_pkg::OUT_W-1:0] o_data
);
    import bwr_pkg::*;

    localparam logic [POS_W-1:0]  FW = POS_W'(FRAME_WIDTH);
    localparam logic [POS_W-1:0]  FH = POS_W'(FRAME_HEIGHT);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    t_bk_state        r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [AREA_W-1:0] r_area;
    logic [AREA_W-1:0] r_rem;
    logic [STEP_W-1:0] r_step;
    logic [LVL_W-1:0] r_level, n_level;
    logic             r_last_rep;
    logic             r_out_vld;
    logic [OUT_W-1:0] r_out;

    logic [POS_W-1:0] rs, re, cs, ce, dr, dc;
    logic [AREA_W:0]  trial;
    logic             fits, out_free;
    logic             do_pop, do_mul, do_div, do_fin;
    logic [PCT_W-1:0] pct;
    logic             raw, deb;

    always_comb begin
        rs = bwr_clip(i_cfg.row_start, FH);
        re = bwr_clip(i_cfg.row_end, FH);
        cs = bwr_clip(i_cfg.col_start, FW);
        ce = bwr_clip(i_cfg.col_end, FW);
        dr = (re > rs) ? re - rs : '0;
        dc = (ce > cs) ? ce - cs : '0;
    end

    assign out_free = !r_out_vld || i_ready;
    assign trial    = {r_rem, r_num[NUM_W-1]};
    assign fits     = trial >= {1'b0, r_area};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (!i_q_empty) n_state = BK_MUL;
            BK_MUL:  n_state = BK_DIV;
            BK_DIV:  if (r_step == LAST_STEP) n_state = BK_FIN;
            BK_FIN:  if (out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        do_pop = 1'b0;
        do_mul = 1'b0;
        do_div = 1'b0;
        do_fin = 1'b0;
        unique case (r_state)
            BK_IDLE: do_pop = !i_q_empty;
            BK_MUL:  do_mul = 1'b1;
            BK_DIV:  do_div = 1'b1;
            BK_FIN:  do_fin = out_free;
            default: ;
        endcase
    end

    assign o_pop = do_pop;

    always_comb begin
        if (r_area == '0) begin
            pct = '0;
        end else if (r_quo > NUM_W'(PCT_MAX)) begin
            pct = PCT_MAX;
        end else begin
            pct = r_quo[PCT_W-1:0];
        end
        raw     = pct >= i_cfg.pct_limit;
        n_level = r_level;
        if (raw) begin
            if (r_level < i_cfg.deb_frames) n_level = r_level + 1'b1;
        end else if (r_level != '0) begin
            n_level = r_level - 1'b1;
        end
        deb = n_level >= i_cfg.deb_frames;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_level    <= '0;
            r_last_rep <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_fin) begin
                r_level    <= n_level;
                r_last_rep <= deb;
                r_out_vld  <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_count <= i_q_head;
        end
        if (do_mul) begin
            r_num  <= NUM_W'(r_count) * NUM_W'(PCT_SCALE);
            r_area <= AREA_W'(dr) * AREA_W'(dc);
            r_rem  <= '0;
            r_quo  <= '0;
            r_step <= '0;
        end
        if (do_div) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= fits ? AREA_W'(trial - {1'b0, r_area}) : trial[AREA_W-1:0];
            r_quo  <= {r_quo[NUM_W-2:0], fits};
            r_step <= r_step + 1'b1;
        end
        if (do_fin) begin
            r_out <= {deb ? CHAR_E : CHAR_S, deb != r_last_rep, deb, raw, pct, r_count};
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/band_white_ratio_edge_detector_unit.sv =====
// Band white-ratio edge detector. Takes one RGB565 pixel per clock in raster order
// (tlast on the last pixel of a frame), counts pixels inside the configured band
// whose luma exceeds luma_limit, and after each frame returns one word with the white
// count, floored white percentage, raw and debounced edge flags, a change flag and
// the report character 'E' or 'S'. Pixel intake sustains one pixel per cycle unless
// stalled; the frame-end result is produced by a serial divider one quotient bit per
// cycle. A two-entry queue between intake and evaluation lets the next frame stream
// in meanwhile; intake stalls only if two frame results are already waiting.
// Configuration writes are always accepted.
module band_white_ratio_edge_detector_unit #(
    parameter int FRAME_WIDTH  = 96,
    parameter int FRAME_HEIGHT = 96
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [bwr_pkg::PIX_W-1:0]      i_s_tdata,   // [15:0] pixel_word
    input  logic                           i_s_tlast,   // frame_last
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [13:0] white_count, [20:14] white_percent, [21] edge_raw,
    // [22] edge_debounced, [23] state_changed, [31:24] report_char
    output logic [bwr_pkg::OUT_W-1:0]      o_m_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bwr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bwr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bwr_pkg::*;

    t_bwr_cfg         r_cfg;
    logic             q_full, q_empty, q_push, q_pop;
    logic [CNT_W-1:0] q_push_data, q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_start  <= RST_ROW_START;
            r_cfg.row_end    <= RST_ROW_END;
            r_cfg.col_start  <= RST_COL_START;
            r_cfg.col_end    <= RST_COL_END;
            r_cfg.pct_limit  <= RST_PCT_LIMIT;
            r_cfg.deb_frames <= RST_DEB_FRAMES;
            r_cfg.luma_limit <= RST_LUMA_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROW_START:  r_cfg.row_start  <= i_cfg_data[POS_W-1:0];
                CFG_ROW_END:    r_cfg.row_end    <= i_cfg_data[POS_W-1:0];
                CFG_COL_START:  r_cfg.col_start  <= i_cfg_data[POS_W-1:0];
                CFG_COL_END:    r_cfg.col_end    <= i_cfg_data[POS_W-1:0];
                CFG_PCT_LIMIT:  r_cfg.pct_limit  <= i_cfg_data[PCT_W-1:0];
                CFG_DEB_FRAMES: r_cfg.deb_frames <= i_cfg_data[LVL_W-1:0];
                CFG_LUMA_LIMIT: r_cfg.luma_limit <= i_cfg_data[LUMA_W-1:0];
                default: ;
            endcase
        end
    end

    bwr_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_pixel     (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    bwr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    bwr_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata)
    );

endmodule

// ===== rtl/core/bwr_checker.sv =====
module bwr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_m_tvalid,
    input logic                      i_m_tready,
    input logic [bwr_pkg::OUT_W-1:0] i_m_tdata
);
    import bwr_pkg::*;

    a_no_word_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result word changed");

    a_char_matches_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[22] && i_m_tdata[31:24] == CHAR_E)
                    || (!i_m_tdata[22] && i_m_tdata[31:24] == CHAR_S))
        else $error("report character disagrees with debounced edge");

    a_zero_count_zero_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[13:0] == '0 |-> i_m_tdata[20:14] == '0)
        else $error("nonzero percentage with zero white count");

endmodule

bind band_white_ratio_edge_detector_unit bwr_checker u_bwr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
